@@ hw/rtl/pidc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the clamped PID controller.
// No dependencies; every other file imports this package.
package pidc_pkg;

	// Datapath width of errors, terms and the integral accumulator (Q16.16)
	localparam int DW        = 32;
	localparam int GAIN_W    = 32;
	localparam int LIM_W     = 31;
	localparam int OUT_W     = 32;
	localparam int IN_DATA_W = 64;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int IDX_W     = 3;

	// Queue between front and back, and the back pipeline depth
	localparam int FIFO_DEPTH   = 4;
	localparam int PIPE_STAGES  = 6;
	localparam int MAX_INFLIGHT = FIFO_DEPTH + PIPE_STAGES;

	// Register index (byte address divided by four)
	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_DERIV_GAIN = 3'd2,
		REG_OUT_LIMIT  = 3'd3,
		REG_INT_LIMIT  = 3'd4
	} reg_idx_t;

	// Reset values of the configuration registers
	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 32'd11492393;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 32'd13254;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 32'd7147094;
	localparam logic [LIM_W-1:0]  OUT_LIMIT_RST  = 31'd58982;
	localparam logic [LIM_W-1:0]  INT_LIMIT_RST  = 31'd557;

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [LIM_W-1:0]  output_limit;
		logic [LIM_W-1:0]  integral_limit;
	} cfg_t;

	// a - b, saturated to the signed DW range
	function automatic logic signed [DW-1:0] sat_sub(
		input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b
	);
		logic signed [DW:0] d;
		logic signed [DW-1:0] r;
		d = {a[DW-1], a} - {b[DW-1], b};
		if (d[DW] != d[DW-1]) begin
			r = d[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			r = d[DW-1:0];
		end
		return r;
	endfunction

	// Clamp to +/- lim; a zero limit forces zero
	function automatic logic signed [DW+1:0] clamp_sym(
		input logic signed [DW+1:0] v,
		input logic [LIM_W-1:0]     lim
	);
		logic signed [DW+1:0] hi;
		logic signed [DW+1:0] lo;
		logic signed [DW+1:0] r;
		hi = $signed({{(DW+2-LIM_W){1'b0}}, lim});
		lo = -hi;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/pid_controller_clamped_top.sv @@
// Positional PID controller with integral and output clamping. Takes one sample
// transaction per clock cycle sustained while the output side is not stalled. The
// rate is set by the integral accumulator, whose add-and-clamp loop holds one
// register; the three gain multipliers are fully pipelined. A four-entry queue
// separates the input side from the back pipeline, so inputs keep being taken while
// a result waits, until the queue is full. Gains and limits are to be written over
// APB only while no transaction is in flight; the block does not enforce this.
// Depends on pidc_pkg, pidc_regs, pidc_front, pidc_fifo, pidc_back.
module pid_controller_clamped_top
	import pidc_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_DATA_W-1:0] s_axis_tdata,  // [31:0] measured, [63:32] setpoint
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [OUT_W-1:0]     m_axis_tdata,  // [31:0] drive
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [APB_DW-1:0]    pwdata,
	output logic [APB_DW-1:0]    prdata,
	output logic                 pready
);

	cfg_t                 cfg;
	logic                 fifo_full;
	logic                 fifo_valid;
	logic                 push;
	logic                 pop;
	logic signed [DW-1:0] err;
	logic [DW-1:0]        fifo_rdata;

	pidc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pidc_front u_front (
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.measured  ($signed(s_axis_tdata[DW-1:0])),
		.setpoint  ($signed(s_axis_tdata[2*DW-1:DW])),
		.fifo_full (fifo_full),
		.push      (push),
		.err       (err)
	);

	pidc_fifo #(
		.WIDTH (DW),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (err),
		.full   (fifo_full),
		.pop    (pop),
		.valid  (fifo_valid),
		.rdata  (fifo_rdata)
	);

	pidc_back #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.fifo_valid  (fifo_valid),
		.fifo_err    ($signed(fifo_rdata)),
		.pop         (pop),
		.drive_valid (m_axis_tvalid),
		.drive_ready (m_axis_tready),
		.drive       (m_axis_tdata)
	);

endmodule

@@ hw/rtl/pidc_regs.sv @@
// APB configuration registers of the PID controller: gains and limits.
// Depends on pidc_pkg.
module pidc_regs
	import pidc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[APB_AW-1:2];
	assign cfg    = cfg_q;

	// Write the addressed register at the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= PROP_GAIN_RST;
			cfg_q.integ_gain     <= INTEG_GAIN_RST;
			cfg_q.deriv_gain     <= DERIV_GAIN_RST;
			cfg_q.output_limit   <= OUT_LIMIT_RST;
			cfg_q.integral_limit <= INT_LIMIT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_PROP_GAIN:  cfg_q.prop_gain      <= pwdata[GAIN_W-1:0];
				REG_INTEG_GAIN: cfg_q.integ_gain     <= pwdata[GAIN_W-1:0];
				REG_DERIV_GAIN: cfg_q.deriv_gain     <= pwdata[GAIN_W-1:0];
				REG_OUT_LIMIT:  cfg_q.output_limit   <= pwdata[LIM_W-1:0];
				REG_INT_LIMIT:  cfg_q.integral_limit <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register, zero beyond the map
	always_comb begin
		case (idx)
			REG_PROP_GAIN:  prdata = cfg_q.prop_gain;
			REG_INTEG_GAIN: prdata = cfg_q.integ_gain;
			REG_DERIV_GAIN: prdata = cfg_q.deriv_gain;
			REG_OUT_LIMIT:  prdata = {1'b0, cfg_q.output_limit};
			REG_INT_LIMIT:  prdata = {1'b0, cfg_q.integral_limit};
			default:        prdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/pidc_front.sv @@
// Front end of the PID controller: accepts samples and forms the saturated error.
// Depends on pidc_pkg; feeds pidc_fifo.
module pidc_front
	import pidc_pkg::*;
(
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [DW-1:0] measured,
	input  logic signed [DW-1:0] setpoint,
	input  logic                 fifo_full,
	output logic                 push,
	output logic signed [DW-1:0] err
);

	// Accept whenever the queue has room
	assign in_ready = !fifo_full;
	assign push     = in_valid & !fifo_full;

	// Error is setpoint minus measured, saturated
	assign err = sat_sub(setpoint, measured);

endmodule

@@ hw/rtl/pidc_fifo.sv @@
// Small register queue that decouples the PID front end from the back pipeline.
// Depends on pidc_pkg.
module pidc_fifo
	import pidc_pkg::*;
#(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == FULL_CNT);
	assign valid = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/pidc_back.sv @@
// Back pipeline of the PID controller: derivative difference, three gain
// products, integral accumulation and output clamp. Depends on pidc_pkg.
module pidc_back
	import pidc_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 fifo_valid,
	input  logic signed [DW-1:0] fifo_err,
	output logic                 pop,
	output logic                 drive_valid,
	input  logic                 drive_ready,
	output logic [OUT_W-1:0]     drive
);

	localparam int PW    = DW + GAIN_W;
	localparam int MAG_W = PW + 1 - GAIN_FRAC_BITS;
	localparam logic [PW:0] HALF = (PW+1)'(1) << (GAIN_FRAC_BITS - 1);
	localparam logic [MAG_W-1:0] LIM_POS = {{(MAG_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [MAG_W-1:0] LIM_NEG = {{(MAG_W-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

	// Round magnitude to nearest (ties away), drop fraction bits, saturate, sign
	function automatic logic signed [DW-1:0] scale(
		input logic [PW-1:0] prod,
		input logic          neg
	);
		logic [PW:0]      rnd;
		logic [MAG_W-1:0] mag;
		logic [MAG_W-1:0] lim;
		logic [DW-1:0]    res;
		rnd = {1'b0, prod} + HALF;
		mag = rnd[PW:GAIN_FRAC_BITS];
		lim = neg ? LIM_NEG : LIM_POS;
		if (mag > lim) begin
			mag = lim;
		end
		res = mag[DW-1:0];
		if (neg) begin
			res = -res;
		end
		return $signed(res);
	endfunction

	logic en;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [DW-1:0] last_err_q;
	logic signed [DW-1:0] integ_q;
	logic signed [DW-1:0] err_s1, diff_s1;
	logic                 neg_err_s2, neg_diff_s2;
	logic [DW-1:0]        mag_err_s2, mag_diff_s2;
	logic                 neg_err_s3, neg_diff_s3;
	logic [PW-1:0]        prod_p_s3, prod_i_s3, prod_d_s3;
	logic signed [DW-1:0] p_s4, i_s4, d_s4;
	logic signed [DW:0]   pd_s5;
	logic [OUT_W-1:0]     drive_s6;

	logic signed [DW+1:0] integ_next;
	logic signed [DW+1:0] total;

	// Whole pipeline moves unless the output register is held
	assign en          = !v_s6 || drive_ready;
	assign pop         = fifo_valid && en;
	assign drive_valid = v_s6;
	assign drive       = drive_s6;

	// Valid bits and the two state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			v_s6       <= 1'b0;
			last_err_q <= '0;
			integ_q    <= '0;
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			if (pop) begin
				last_err_q <= fifo_err;
			end
			if (v_s4) begin
				integ_q <= integ_next[DW-1:0];
			end
		end
	end

	// Integral step: add the scaled error and clamp to the integral limit
	assign integ_next = clamp_sym({{2{i_s4[DW-1]}}, i_s4} + {{2{integ_q[DW-1]}}, integ_q},
		cfg.integral_limit);

	// Output sum with the freshly updated accumulator, clamped to the output limit
	assign total = clamp_sym({pd_s5[DW], pd_s5} + {{2{integ_q[DW-1]}}, integ_q},
		cfg.output_limit);

	// Datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: take the error and form the saturated difference
			err_s1  <= fifo_err;
			diff_s1 <= sat_sub(fifo_err, last_err_q);
			// s2: split into sign and magnitude
			neg_err_s2  <= err_s1[DW-1];
			mag_err_s2  <= err_s1[DW-1] ? -err_s1 : err_s1;
			neg_diff_s2 <= diff_s1[DW-1];
			mag_diff_s2 <= diff_s1[DW-1] ? -diff_s1 : diff_s1;
			// s3: gain products
			neg_err_s3  <= neg_err_s2;
			neg_diff_s3 <= neg_diff_s2;
			prod_p_s3   <= PW'(mag_err_s2) * PW'(cfg.prop_gain);
			prod_i_s3   <= PW'(mag_err_s2) * PW'(cfg.integ_gain);
			prod_d_s3   <= PW'(mag_diff_s2) * PW'(cfg.deriv_gain);
			// s4: round and saturate each term
			p_s4 <= scale(prod_p_s3, neg_err_s3);
			i_s4 <= scale(prod_i_s3, neg_err_s3);
			d_s4 <= scale(prod_d_s3, neg_diff_s3);
			// s5: proportional plus derivative
			pd_s5 <= {p_s4[DW-1], p_s4} + {d_s4[DW-1], d_s4};
			// s6: output register
			drive_s6 <= total[OUT_W-1:0];
		end
	end

endmodule

@@ hw/rtl/pidc_checker.sv @@
// Port-level checker for the PID controller top level, attached with bind.
// Depends on pidc_pkg and pid_controller_clamped_top.
module pidc_checker
	import pidc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	localparam int CNT_W = $clog2(MAX_INFLIGHT + 2);

	logic [CNT_W-1:0] inflight_q;
	logic in_xfer;
	logic out_xfer;

	assign in_xfer  = s_axis_tvalid & s_axis_tready;
	assign out_xfer = m_axis_tvalid & m_axis_tready;

	// Track transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_xfer && !in_xfer && inflight_q != '0) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	// Result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("drive valid dropped while stalled");

	// Offered result does not change while stalled
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("drive changed while stalled");

	// No result without an accepted sample behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> (inflight_q != '0 || in_xfer))
		else $error("result delivered with no sample in flight");

	// Queue plus pipeline bound the samples in flight
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(MAX_INFLIGHT))
		else $error("more samples in flight than storage allows");

endmodule

bind pid_controller_clamped_top pidc_checker u_pidc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

@@ bench/pid_drive_checker.sv @@
`timescale 1ns / 100ps
// Checker for the clamped PID controller: follows the APB register writes, computes the
// expected drive for every accepted sample and compares it with each output transaction.
// Depends on pidc_pkg for widths, register indexes and reset values.
module pid_drive_checker
	import pidc_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [IN_DATA_W-1:0] s_axis_tdata,  // [31:0] measured, [63:32] setpoint
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [OUT_W-1:0]     m_axis_tdata,  // [31:0] drive
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [APB_DW-1:0]    pwdata,
	output int                   pending,
	output int                   fail_count
);

	// Shadow copy of the gains and limits
	logic [GAIN_W-1:0] kp;
	logic [GAIN_W-1:0] ki;
	logic [GAIN_W-1:0] kd;
	logic [LIM_W-1:0]  out_lim;
	logic [LIM_W-1:0]  int_lim;

	// Controller history
	longint prev_err;
	longint integ_acc;

	logic [OUT_W-1:0] drive_q[$];
	logic [OUT_W-1:0] want;
	int               error_tally;

	// Saturate to the signed datapath range
	function automatic longint sat_word(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (DW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// Symmetric clamp; a zero bound yields zero
	function automatic longint clamp_limit(longint v, logic [LIM_W-1:0] lim);
		longint l;
		l = longint'(lim);
		if (v > l) return l;
		if (v < -l) return -l;
		return v;
	endfunction

	// Multiply by an unsigned gain: round the magnitude half away from zero, then saturate
	function automatic longint scale_by_gain(longint v, logic [GAIN_W-1:0] g);
		logic [63:0] mag;
		logic [63:0] prod;
		logic [63:0] cap;
		mag  = (v < 0) ? -v : v;
		prod = mag * {32'd0, g} + (64'd1 << (GAIN_FRAC_BITS - 1));
		prod = prod >> GAIN_FRAC_BITS;
		cap  = (v < 0) ? (64'd1 << (DW - 1)) : ((64'd1 << (DW - 1)) - 1);
		if (prod > cap) prod = cap;
		return (v < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	// Advance the controller by one sample and return the expected drive
	function automatic logic [OUT_W-1:0] compute_drive(logic [31:0] meas_bits,
			logic [31:0] sp_bits);
		longint meas;
		longint sp;
		longint err;
		longint diff;
		longint p_term;
		longint d_term;
		longint total;
		meas      = longint'($signed(meas_bits));
		sp        = longint'($signed(sp_bits));
		err       = sat_word(sp - meas);
		diff      = sat_word(err - prev_err);
		p_term    = scale_by_gain(err, kp);
		d_term    = scale_by_gain(diff, kd);
		integ_acc = clamp_limit(sat_word(integ_acc + scale_by_gain(err, ki)), int_lim);
		prev_err  = err;
		total     = clamp_limit(p_term + integ_acc + d_term, out_lim);
		if (total > 64'sd2147483647) total = 64'sd2147483647;
		if (total < -64'sd2147483648) total = -64'sd2147483648;
		return total[OUT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp          = PROP_GAIN_RST;
			ki          = INTEG_GAIN_RST;
			kd          = DERIV_GAIN_RST;
			out_lim     = OUT_LIMIT_RST;
			int_lim     = INT_LIMIT_RST;
			prev_err    = 0;
			integ_acc   = 0;
			error_tally = 0;
			drive_q.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			// Check the output transaction against the oldest expectation
			if (m_axis_tvalid && m_axis_tready) begin
				if (drive_q.size() == 0) begin
					error_tally++;
					$display("%0t: unexpected drive, expected none, actual %0d",
						$time, $signed(m_axis_tdata));
				end else begin
					want = drive_q.pop_front();
					if (m_axis_tdata !== want) begin
						error_tally++;
						$display("%0t: drive mismatch, expected %0d, actual %0d",
							$time, $signed(want), $signed(m_axis_tdata));
					end
				end
			end

			// Predict the drive for the accepted sample
			if (s_axis_tvalid && s_axis_tready)
				drive_q.push_back(compute_drive(s_axis_tdata[31:0], s_axis_tdata[63:32]));

			// Track register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_AW-1:2]))
					REG_PROP_GAIN:  kp = pwdata;
					REG_INTEG_GAIN: ki = pwdata;
					REG_DERIV_GAIN: kd = pwdata;
					REG_OUT_LIMIT:  out_lim = pwdata[LIM_W-1:0];
					REG_INT_LIMIT:  int_lim = pwdata[LIM_W-1:0];
					default: ;
				endcase
			end

			pending    <= drive_q.size();
			fail_count <= error_tally;
		end
	end

endmodule

@@ bench/tb_pid_controller_clamped_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the clamped PID controller: clock, reset, sample and APB stimulus,
// output back-pressure and the final verdict. Depends on pidc_pkg and pid_drive_checker.
module tb_pid_controller_clamped_top;
	import pidc_pkg::*;

	localparam logic [31:0] Q_MIN     = 32'h8000_0000;
	localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_ONE     = 32'h0001_0000;
	localparam logic [31:0] GAIN_HALF = 32'h0080_0000;
	localparam logic [31:0] GAIN_MAX  = 32'hFFFF_FFFF;
	localparam logic [31:0] LIM_MAX   = 32'h7FFF_FFFF;
	localparam int          PHASES    = 7;
	localparam int          PHASE_LEN = 250;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;  // [31:0] measured, [63:32] setpoint
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;  // [31:0] drive
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	int pending;
	int fail_count;

	bit tx_idle;
	bit rx_idle;
	bit sink_hold_req;

	pid_controller_clamped_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	pid_drive_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pending       (pending),
		.fail_count    (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the flow hangs
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Output back-pressure: random stall bursts and one long hold on request
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (sink_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
				sink_hold_req = 1'b0;
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offer one sample, with an optional idle burst first; hold it until accepted
	task automatic send_sample(logic [31:0] meas, logic [31:0] sp);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {sp, meas};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop offering and wait until every expected drive has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_config(logic [31:0] p, logic [31:0] i, logic [31:0] d,
			logic [31:0] olim, logic [31:0] ilim);
		drain();
		write_reg(REG_PROP_GAIN, p);
		write_reg(REG_INTEG_GAIN, i);
		write_reg(REG_DERIV_GAIN, d);
		write_reg(REG_OUT_LIMIT, olim);
		write_reg(REG_INT_LIMIT, ilim);
	endtask

	// Sample value: extremes, small values around zero, or anything
	function automatic logic [31:0] pick_q16();
		case ($urandom_range(0, 7))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
			3, 4: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return GAIN_MAX;
			2: return $urandom;
			default: return $urandom_range(0, 32'h0400_0000);
		endcase
	endfunction

	// Bit 31 is random: the register keeps 31 bits only
	function automatic logic [31:0] pick_limit();
		logic [30:0] lim;
		case ($urandom_range(0, 5))
			0: lim = '0;
			1: lim = LIM_MAX[30:0];
			2: lim = 31'($urandom);
			default: lim = 31'($urandom_range(0, 32'h0020_0000));
		endcase
		return {1'($urandom_range(0, 1)), lim};
	endfunction

	task automatic random_sample();
		logic [31:0] meas;
		logic [31:0] sp;
		meas = pick_q16();
		if ($urandom_range(0, 1))
			sp = meas + 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
		else
			sp = pick_q16();
		send_sample(meas, sp);
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		tx_idle       = 1'b0;
		rx_idle       = 1'b0;
		sink_hold_req = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset gains: zero error, small errors, saturating errors and error steps
		send_sample(32'd0, 32'd0);
		send_sample(32'd0, 32'd1);
		send_sample(32'd1, 32'd0);
		send_sample(Q_MIN, Q_MAX);
		send_sample(Q_MAX, Q_MIN);
		send_sample(Q_MAX, Q_MAX);
		send_sample(Q_ONE, -Q_ONE);

		// Half gains: ties on the product rounding, both signs
		load_config(GAIN_HALF, GAIN_HALF, GAIN_HALF, LIM_MAX, LIM_MAX);
		send_sample(32'd0, 32'd1);
		send_sample(32'd0, 32'hFFFF_FFFF);
		send_sample(32'd0, 32'd3);
		send_sample(32'd3, 32'd0);

		// Full-scale gains and bounds: product, integral and sum saturation
		load_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, LIM_MAX, LIM_MAX);
		send_sample(Q_MIN, Q_MAX);
		send_sample(Q_MAX, Q_MIN);
		send_sample(32'd0, 32'hFFFF_FFFF);
		send_sample(32'hFFFF_FFFF, 32'd0);
		send_sample(Q_MAX, Q_MAX);

		// Zero bounds force zero output and a zero integral
		load_config(GAIN_MAX, 32'h0100_0000, 32'h0100_0000, 32'd0, 32'd0);
		send_sample(Q_MIN, Q_MAX);
		send_sample(32'd0, Q_ONE);
		send_sample(Q_ONE, 32'd0);
		send_sample(32'd0, 32'd0);

		// Random phases, each under its own register setting
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES - 1) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			load_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
			if (ph == 2) begin
				// Hold the output side and keep offering so the block backs up
				tx_idle       = 1'b0;
				sink_hold_req = 1'b1;
			end
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (ph == 2 && n == 60)
					tx_idle = 1'b1;
				if (ph == 4 && n == PHASE_LEN / 2)
					drain();
				random_sample();
			end
		end

		drain();
		repeat (PIPE_STAGES + 6) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_regs.sv
hw/rtl/pidc_front.sv
hw/rtl/pidc_fifo.sv
hw/rtl/pidc_back.sv
hw/rtl/pid_controller_clamped_top.sv
hw/rtl/pidc_checker.sv
bench/pid_drive_checker.sv
bench/tb_pid_controller_clamped_top.sv
